[src/sorted_access_set_checker_macros.svh]
// Assertion macros for the sorted access set checker.
`ifndef SORTED_ACCESS_SET_CHECKER_MACROS_SVH
`define SORTED_ACCESS_SET_CHECKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SAC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sac: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sac: next-cycle check failed");

`endif

[src/sac_pkg.sv]
// Types, codes and sizes shared by the sorted access set checker.
`default_nettype none
package sac_pkg;

  localparam int unsigned MAX_ENTRIES = 32;
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    MODE_DECLARE  = 2'd0,
    MODE_CHECK    = 2'd1,
    MODE_CONFLICT = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SAME      = 2'd1,
    ST_DIFFERENT = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_EXCLUDE = 2'd2;

  typedef struct packed {
    logic [1:0]  domain;
    logic [31:0] ident;
    logic [1:0]  kind;
  } entry_t;

  typedef struct packed {
    logic       found;
    logic [1:0] kind;
  } lookup_t;

  typedef struct packed {
    mode_e       mode;
    logic [1:0]  domain;
    logic [31:0] ident;
    logic [1:0]  access_kind;
    logic        last_entry;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic        found;
    logic [1:0]  declared_kind;
    logic        permitted;
    logic        conflict;
    logic [31:0] violation_count;
    logic [31:0] last_violation_ident;
    logic [5:0]  entry_count;
  } out_t;

endpackage
`default_nettype wire

[src/sac_cell.sv]
// One table slot: compares against the search key and shifts on insert.
`default_nettype none
module sac_cell import sac_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   occ_i,
  input  wire logic   ins_i,
  input  wire entry_t key_i,
  input  wire logic   prev_less_i,
  input  wire entry_t prev_entry_i,
  output entry_t      entry_o,
  output logic        less_o,
  output logic        hit_o
);

  entry_t     entry_q;
  logic [33:0] own_key;
  logic [33:0] new_key;

  assign own_key = {entry_q.domain, entry_q.ident};
  assign new_key = {key_i.domain, key_i.ident};

  assign less_o  = occ_i && (own_key < new_key);
  assign hit_o   = occ_i && (own_key == new_key);
  assign entry_o = entry_q;

  // Slots past the insert point take their neighbor; the insert point takes the new entry.
  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      if (!prev_less_i) begin
        entry_q <= prev_entry_i;
      end else if (!less_o) begin
        entry_q <= key_i;
      end
    end
  end

endmodule
`default_nettype wire

[src/sac_table.sv]
// Sorted table built as a chain of slots, with lookup reduction.
`default_nettype none
module sac_table import sac_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic             ins_i,
  input  wire entry_t           key_i,
  output lookup_t               lookup_o
);

  entry_t                 entries [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] less;
  logic [MAX_ENTRIES-1:0] hit;
  logic [1:0]             kind_w;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic   occ;
    logic   prev_less;
    entry_t prev_entry;

    assign occ = count_i > CNT_W'(g);

    if (g == 0) begin : g_head
      assign prev_less  = 1'b1;
      assign prev_entry = key_i;
    end else begin : g_body
      assign prev_less  = less[g-1];
      assign prev_entry = entries[g-1];
    end

    sac_cell u_cell (
      .clk_i        (clk_i),
      .occ_i        (occ),
      .ins_i        (ins_i),
      .key_i        (key_i),
      .prev_less_i  (prev_less),
      .prev_entry_i (prev_entry),
      .entry_o      (entries[g]),
      .less_o       (less[g]),
      .hit_o        (hit[g])
    );
  end

  // Keys are unique, so at most one slot hits.
  always_comb begin
    kind_w = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (hit[k]) begin
        kind_w = kind_w | entries[k].kind;
      end
    end
  end

  assign lookup_o.found = |hit;
  assign lookup_o.kind  = kind_w;

endmodule
`default_nettype wire

[src/sorted_access_set_checker.sv]
// Top level of the sorted access set checker: mode control, counters, result register.
//
//   channel | signals                          | payload
//   --------+----------------------------------+------------------------------
//   in      | in_valid_i / in_ready_o          | in_i  (mode, key, kind, last)
//   out     | out_valid_o / out_ready_i        | out_o (status, lookup, counts)
//
// One item per cycle while the output is not stalled: every slot compares its key in
// parallel and an insert shifts the chain by one slot in the same cycle.
// The result register lets a new item in while the previous result is taken.
// Reset empties the table and clears counters; no clearing pass is needed.
// A stalled output holds the result and blocks further input transfers.
`default_nettype none
`include "sorted_access_set_checker_macros.svh"
module sorted_access_set_checker import sac_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      viol_q, viol_d;
  logic [31:0]      last_id_q, last_id_d;
  logic             seen_q, seen_d;
  logic             out_valid_q;
  out_t             out_q, out_d;

  logic             acc;
  logic             full;
  logic             ins;
  logic             ok;
  logic             kinds_clash;
  logic             conflict;
  entry_t           new_entry;
  lookup_t          lookup;
  logic [CNT_W+5:0] count_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign full       = count_q == CNT_W'(MAX_ENTRIES);

  assign new_entry.domain = in_i.domain;
  assign new_entry.ident  = in_i.ident;
  assign new_entry.kind   = in_i.access_kind;

  assign ins = acc && (in_i.mode == MODE_DECLARE) && !lookup.found && !full;

  sac_table u_table (
    .clk_i    (clk_i),
    .count_i  (count_q),
    .ins_i    (ins),
    .key_i    (new_entry),
    .lookup_o (lookup)
  );

  assign ok = lookup.found && ((lookup.kind == KIND_WRITE) ?
                               (in_i.access_kind != KIND_EXCLUDE) :
                               (lookup.kind == in_i.access_kind));

  assign kinds_clash = (lookup.kind != KIND_EXCLUDE) && (in_i.access_kind != KIND_EXCLUDE) &&
                       ((lookup.kind == KIND_WRITE) || (in_i.access_kind == KIND_WRITE));
  assign conflict    = lookup.found && !seen_q && kinds_clash;

  // Next state of the counters and flags.
  always_comb begin
    count_d   = count_q;
    viol_d    = viol_q;
    last_id_d = last_id_q;
    seen_d    = seen_q;
    if (acc) begin
      case (in_i.mode)
        MODE_DECLARE: begin
          if (ins) begin
            count_d = count_q + CNT_W'(1);
          end
        end
        MODE_CHECK: begin
          if (!ok) begin
            viol_d    = (viol_q == '1) ? viol_q : viol_q + 32'd1;
            last_id_d = in_i.ident;
          end
        end
        MODE_CONFLICT: begin
          // Flag the first clash only; the last entry ends the run.
          if (in_i.last_entry) begin
            seen_d = 1'b0;
          end else if (conflict) begin
            seen_d = 1'b1;
          end
        end
        MODE_CLEAR: begin
          viol_d    = '0;
          last_id_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  assign count_ext = {6'd0, count_d};

  // Result fields.
  always_comb begin
    out_d                      = '0;
    out_d.status               = ST_OK;
    out_d.found                = lookup.found;
    out_d.declared_kind        = lookup.found ? lookup.kind : 2'd0;
    out_d.violation_count      = viol_d;
    out_d.last_violation_ident = last_id_d;
    out_d.entry_count          = count_ext[5:0];
    case (in_i.mode)
      MODE_DECLARE: begin
        if (lookup.found) begin
          out_d.status = (lookup.kind == in_i.access_kind) ? ST_SAME : ST_DIFFERENT;
        end else if (full) begin
          out_d.status = ST_FULL;
        end
      end
      MODE_CHECK: begin
        out_d.permitted = ok;
      end
      MODE_CONFLICT: begin
        out_d.conflict = conflict;
      end
      MODE_CLEAR: begin
        out_d.found         = 1'b0;
        out_d.declared_kind = 2'd0;
      end
      default: begin
        out_d.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      viol_q      <= '0;
      last_id_q   <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      viol_q    <= viol_d;
      last_id_q <= last_id_d;
      seen_q    <= seen_d;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SAC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_ENTRIES))
  `SAC_ASSERT_NEXT(a_insert_grows, ins, count_q == $past(count_q) + CNT_W'(1))
  `SAC_ASSERT_NEXT(a_clear_zeroes, acc && (in_i.mode == MODE_CLEAR),
                   (viol_q == '0) && (last_id_q == '0))
  `SAC_ASSERT_NEXT(a_viol_monotone, !(acc && (in_i.mode == MODE_CLEAR)),
                   viol_q >= $past(viol_q))
  `SAC_ASSERT_NEXT(a_run_end, acc && (in_i.mode == MODE_CONFLICT) && in_i.last_entry,
                   !seen_q)

endmodule
`default_nettype wire
